### rtl/core/tsof_pkg.sv
`timescale 1ns / 1ps
// tsof_pkg: shared types and fixed port widths of the two-sigma outlier filter
// no dependencies

package tsof_pkg;

  localparam int IN_VALUE_W  = 12;
  localparam int OUT_INDEX_W = 6;
  localparam int OUT_VALUE_W = 12;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP_MUL,
    ST_PREP_SUB,
    ST_READ,
    ST_MUL,
    ST_SQR,
    ST_OUT
  } state_t;

endpackage

### rtl/core/two_sigma_outlier_filter_unit.sv
`timescale 1ns / 1ps
// two_sigma_outlier_filter_unit: collects a set of measurements, then reports each
// one with a flag telling whether it lies strictly within two sigma of the mean
// depends on tsof_pkg

// Measurements load one word per cycle, while the unit is in its load state, into
// a value memory with one write and one read port while the count N, the sum S
// and the sum of squares Q are kept in registers. The word carrying the last mark
// closes the set: the PREP_MUL and PREP_SUB states then form 4*(N*Q - S^2), and
// the memory is walked in arrival order, each result passing through the memory
// read, N*v, the square of |N*v - S| and the compare into the output register,
// which waits while the output side stalls. Words beyond MAX_ITEMS are dropped,
// though a last mark on such a word still closes the set. A set whose values are
// all equal keeps none. The next set starts loading while the final result of
// the previous one still waits to be taken.

module two_sigma_outlier_filter_unit #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tsof_pkg::IN_VALUE_W-1:0]    in_sample_value,
  input  logic                               in_last_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tsof_pkg::OUT_INDEX_W-1:0]   out_item_index,
  output logic [tsof_pkg::OUT_VALUE_W-1:0]   out_item_value,
  output logic                               out_keep,
  output logic                               out_last_of_run
);

  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W  = $clog2(MAX_ITEMS);
  localparam int SUM_W   = VALUE_BITS + CNT_W;
  localparam int SQ_W    = 2 * VALUE_BITS + CNT_W;
  localparam int NQ_W    = CNT_W + SQ_W;
  localparam int VAR_W   = NQ_W + 2;
  localparam int IN_EXT_W  = (VALUE_BITS > tsof_pkg::IN_VALUE_W) ?
                             VALUE_BITS : tsof_pkg::IN_VALUE_W;
  localparam int OUT_EXT_W = (VALUE_BITS > tsof_pkg::OUT_VALUE_W) ?
                             VALUE_BITS : tsof_pkg::OUT_VALUE_W;
  localparam int IDX_EXT_W = (ADDR_W > tsof_pkg::OUT_INDEX_W) ?
                             ADDR_W : tsof_pkg::OUT_INDEX_W;

  logic [VALUE_BITS-1:0] mem [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rd_data_r;

  tsof_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [ADDR_W-1:0]     k_r, k_nxt;
  logic [NQ_W-1:0]       nq_r, nq_nxt;
  logic [NQ_W-1:0]       ss_r, ss_nxt;
  logic [VAR_W-1:0]      var4_r, var4_nxt;
  logic [SUM_W-1:0]      nv_r, nv_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [NQ_W-1:0]       d2_r, d2_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [tsof_pkg::OUT_INDEX_W-1:0]   out_index_r, out_index_nxt;
  logic [tsof_pkg::OUT_VALUE_W-1:0]   out_value_r, out_value_nxt;
  logic                               out_keep_r, out_keep_nxt;
  logic                               out_last_r, out_last_nxt;

  logic [IN_EXT_W-1:0]     in_ext;
  logic [VALUE_BITS-1:0]   in_v;
  logic [2*VALUE_BITS-1:0] in_v_sq;
  logic                    full;
  logic                    in_fire;
  logic                    mem_we;
  logic [NQ_W-1:0]         nq_full;
  logic [NQ_W-1:0]         ss_full;
  logic [SUM_W-1:0]        nv_full;
  logic [SUM_W-1:0]        dev;
  logic [NQ_W-1:0]         d2_full;
  logic [OUT_EXT_W-1:0]    val_ext;
  logic [IDX_EXT_W-1:0]    idx_ext;
  logic                    is_final;

  assign in_ext   = IN_EXT_W'(in_sample_value);
  assign in_v     = in_ext[VALUE_BITS-1:0];
  assign in_v_sq  = in_v * in_v;
  assign full     = (cnt_r == CNT_W'(MAX_ITEMS));
  assign in_ready = (state_r == tsof_pkg::ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign mem_we   = in_fire && !full;

  assign nq_full  = cnt_r * sq_r;
  assign ss_full  = sum_r * sum_r;
  assign nv_full  = cnt_r * rd_data_r;
  assign dev      = (nv_r >= sum_r) ? (nv_r - sum_r) : (sum_r - nv_r);
  assign d2_full  = dev * dev;
  assign val_ext  = OUT_EXT_W'(val_r);
  assign idx_ext  = IDX_EXT_W'(k_r);
  assign is_final = ((CNT_W'(k_r) + CNT_W'(1)) == cnt_r);

  // value memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_v;
    end
    rd_data_r <= mem[k_r];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    k_nxt         = k_r;
    nq_nxt        = nq_r;
    ss_nxt        = ss_r;
    var4_nxt      = var4_r;
    nv_nxt        = nv_r;
    val_nxt       = val_r;
    d2_nxt        = d2_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_keep_nxt  = out_keep_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      tsof_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (!full) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            sum_nxt = sum_r + SUM_W'(in_v);
            sq_nxt  = sq_r + SQ_W'(in_v_sq);
          end
          if (in_last_sample) begin
            k_nxt     = '0;
            state_nxt = tsof_pkg::ST_PREP_MUL;
          end
        end
      end
      tsof_pkg::ST_PREP_MUL: begin
        nq_nxt    = nq_full;
        ss_nxt    = ss_full;
        state_nxt = tsof_pkg::ST_PREP_SUB;
      end
      tsof_pkg::ST_PREP_SUB: begin
        // zero variance leaves the bound at zero so nothing passes
        var4_nxt  = (nq_r > ss_r) ? {nq_r - ss_r, 2'b00} : '0;
        state_nxt = tsof_pkg::ST_READ;
      end
      tsof_pkg::ST_READ: begin
        state_nxt = tsof_pkg::ST_MUL;
      end
      tsof_pkg::ST_MUL: begin
        nv_nxt    = nv_full;
        val_nxt   = rd_data_r;
        state_nxt = tsof_pkg::ST_SQR;
      end
      tsof_pkg::ST_SQR: begin
        d2_nxt    = d2_full;
        state_nxt = tsof_pkg::ST_OUT;
      end
      tsof_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = idx_ext[tsof_pkg::OUT_INDEX_W-1:0];
          out_value_nxt = val_ext[tsof_pkg::OUT_VALUE_W-1:0];
          out_keep_nxt  = (VAR_W'(d2_r) < var4_r);
          out_last_nxt  = is_final;
          if (is_final) begin
            cnt_nxt   = '0;
            sum_nxt   = '0;
            sq_nxt    = '0;
            state_nxt = tsof_pkg::ST_LOAD;
          end else begin
            k_nxt     = k_r + ADDR_W'(1);
            state_nxt = tsof_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = tsof_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsof_pkg::ST_LOAD;
      cnt_r       <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nq_r        <= nq_nxt;
    ss_r        <= ss_nxt;
    var4_r      <= var4_nxt;
    nv_r        <= nv_nxt;
    val_r       <= val_nxt;
    d2_r        <= d2_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_keep_r  <= out_keep_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_item_index  = out_index_r;
  assign out_item_value  = out_value_r;
  assign out_keep        = out_keep_r;
  assign out_last_of_run = out_last_r;

endmodule
